### rtl/paired_page_table_mapper_macros.svh
// Assertion macros for the paired page table mapper.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef PAIRED_PAGE_TABLE_MAPPER_MACROS_SVH
`define PAIRED_PAGE_TABLE_MAPPER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPTM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPTM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/pptm_pkg.sv
// Shared types and constants of the paired page table mapper.
// Used by the table cell and the top level; depends on nothing else.
package pptm_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W      = 8;
	localparam int TAG_W       = 19;
	localparam int FRAME_W     = 20;
	localparam int SPACE_W     = 8;
	localparam int ENTRY_W     = TAG_W + SPACE_W;
	localparam int HALF_W      = FRAME_W + 2;
	localparam int TAG_LSB     = 13;
	localparam int FRAME_LSB   = 12;
	localparam int ODD_BIT     = 12;

	localparam logic REQ_MAP   = 1'b0;
	localparam logic REQ_DIRTY = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_MAPPED   = 2'd1,
		STAT_FULL     = 2'd2,
		STAT_UNMAPPED = 2'd3
	} status_t;

	// Request fields held for the whole search and seen by every cell.
	typedef struct packed {
		logic               req_type;
		logic [TAG_W-1:0]   tag;
		logic               odd;
		logic [FRAME_W-1:0] frame;
		logic               we;
	} req_t;

	// Search token handed from cell to cell.
	typedef struct packed {
		logic              valid;
		logic              done;
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  rem;
		logic              appended;
	} tok_t;

endpackage

### rtl/pptm_cell.sv
// One entry of the page table together with its stage of the search chain.
// Depends on pptm_pkg for the request and token types.
module pptm_cell
	import pptm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  req_t               req,
	input  logic [SPACE_W-1:0] space_id,
	input  tok_t               tok_in,
	output tok_t               tok_out
);

	logic [ENTRY_W-1:0] tag_q;
	logic [HALF_W-1:0]  even_q;
	logic [HALF_W-1:0]  odd_q;
	tok_t               tok_q;

	logic              in_use;
	logic              match;
	logic [HALF_W-1:0] cur_half;
	logic [HALF_W-1:0] new_half;
	logic              wr_hit;
	logic              wr_new;
	tok_t              nxt;

	always_comb begin
		in_use   = (tok_in.rem != '0);
		match    = in_use && (tag_q[ENTRY_W-1:SPACE_W] == req.tag);
		cur_half = req.odd ? odd_q : even_q;
		nxt      = tok_in;
		nxt.idx  = IDX_W'(tok_in.idx + 1'b1);
		nxt.rem  = in_use ? CNT_W'(tok_in.rem - 1'b1) : '0;
		wr_hit   = 1'b0;
		wr_new   = 1'b0;
		new_half = {req.frame, req.we, 1'b1};
		if (tok_in.valid && !tok_in.done) begin
			if (match) begin
				nxt.done = 1'b1;
				if (req.req_type == REQ_MAP) begin
					if (cur_half[0]) begin
						nxt.status = STAT_MAPPED;
					end else begin
						nxt.status = STAT_OK;
						nxt.slot   = SLOT_W'(tok_in.idx);
						wr_hit     = 1'b1;
					end
				end else begin
					if (!cur_half[0]) begin
						nxt.status = STAT_UNMAPPED;
					end else begin
						nxt.status = STAT_OK;
						nxt.slot   = SLOT_W'(tok_in.idx);
						new_half   = {cur_half[HALF_W-1:2], req.we, cur_half[0]};
						wr_hit     = 1'b1;
					end
				end
			end else if (!in_use && (req.req_type == REQ_MAP)) begin
				nxt.done     = 1'b1;
				nxt.status   = STAT_OK;
				nxt.slot     = SLOT_W'(tok_in.idx);
				nxt.appended = 1'b1;
				wr_new       = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			if (req.odd) begin
				odd_q <= new_half;
			end else begin
				even_q <= new_half;
			end
		end else if (wr_new) begin
			tag_q  <= {req.tag, space_id};
			odd_q  <= req.odd ? new_half : '0;
			even_q <= req.odd ? '0 : new_half;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

### rtl/paired_page_table_mapper.sv
// Top level of the paired page table mapper: request capture, cell chain and result register.
// Depends on pptm_pkg, pptm_cell and paired_page_table_mapper_macros.svh.
//
// A request is taken when start is high and busy is low, and its result appears on status
// and slot with done high for exactly one cycle; the receiver cannot stall it, so it must
// take every result in that cycle. The search token walks the chain of table cells one cell
// per clock, through the head register, every cell register and then the result register,
// whatever the fill level, and busy stays high until the result strobe.
// Requests are handled one at a time. The address space id register may be written at any
// time through cfg_valid and cfg_data, but only while the block is idle does a write have a
// defined effect on the next new entry. Table entries need no clearing after reset.
`include "paired_page_table_mapper_macros.svh"

module paired_page_table_mapper
	import pptm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 req_type,
	input  logic [31:0]          virt_addr,
	input  logic [31:0]          phys_addr,
	input  logic                 write_enable,
	output logic                 done,
	output logic [1:0]           status,
	output logic [SLOT_W-1:0]    slot,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [SPACE_W-1:0]   cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	state_t             state_q;
	req_t               req_q;
	logic [SPACE_W-1:0] space_q;
	logic [CNT_W-1:0]   used_q;
	tok_t               head_q;
	logic               done_q;
	status_t            status_q;
	logic [SLOT_W-1:0]  slot_q;

	tok_t               chain [TABLE_DEPTH+1];
	tok_t               tail;
	tok_t               head_d;
	logic               accept;
	status_t            fin_status;
	logic [SLOT_W-1:0]  fin_slot;

	assign busy      = (state_q == ST_BUSY);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			space_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.req_type <= req_type;
			req_q.tag      <= virt_addr[31:TAG_LSB];
			req_q.odd      <= virt_addr[ODD_BIT];
			req_q.frame    <= phys_addr[31:FRAME_LSB];
			req_q.we       <= write_enable;
		end
	end

	always_comb begin
		head_d          = '0;
		head_d.valid    = accept;
		head_d.status   = STAT_OK;
		head_d.rem      = used_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q <= head_d;
		end
	end

	assign chain[0] = head_q;

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
		pptm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.req      (req_q),
			.space_id (space_q),
			.tok_in   (chain[k]),
			.tok_out  (chain[k+1])
		);
	end

	assign tail = chain[TABLE_DEPTH];

	always_comb begin
		if (tail.done) begin
			fin_status = tail.status;
		end else if (req_q.req_type == REQ_MAP) begin
			fin_status = STAT_FULL;
		end else begin
			fin_status = STAT_UNMAPPED;
		end
		fin_slot = (tail.done && (tail.status == STAT_OK)) ? tail.slot : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			used_q   <= '0;
			done_q   <= 1'b0;
			status_q <= STAT_OK;
			slot_q   <= '0;
		end else begin
			done_q <= tail.valid;
			if (tail.valid) begin
				status_q <= fin_status;
				slot_q   <= fin_slot;
				if (tail.appended) begin
					used_q <= CNT_W'(used_q + 1'b1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (tail.valid) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;

	`PPTM_ASSERT_NOW(a_count_bound, 1'b1, used_q <= CNT_W'(TABLE_DEPTH), "used count above depth")
	`PPTM_ASSERT_NOW(a_append_room, tail.valid && tail.appended, used_q < CNT_W'(TABLE_DEPTH), "append into full table")
	`PPTM_ASSERT_NOW(a_tail_busy, tail.valid, state_q == ST_BUSY, "search beat left chain while idle")
	`PPTM_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "request taken without going busy")
	`PPTM_ASSERT_NOW(a_error_slot, done && (status != STAT_OK), slot == '0, "nonzero slot on fault")

endmodule

### verif/paired_page_table_mapper_tb.sv
// Self-checking testbench for paired_page_table_mapper: directed probes, then random map and
// set-dirty traffic checked against an in-bench model of the paired page table.
// Depends on pptm_pkg and the paired_page_table_mapper RTL.
module paired_page_table_mapper_tb;
	import pptm_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 400;
	localparam int MAX_GAP        = 320;
	localparam int DRAIN_CYCLES   = 300;
	localparam int PROBE_COUNT    = 17;

	typedef struct packed {
		status_t           st;
		logic [SLOT_W-1:0] slot;
	} map_result_t;

	typedef struct packed {
		logic              rq;
		logic [31:0]       va;
		logic [31:0]       pa;
		logic              we;
		logic              typed;
		status_t           st;
		logic [SLOT_W-1:0] slot;
	} probe_row_t;

	// Rows with typed set carry their own expected result; the rest use the table model.
	localparam probe_row_t PROBE_ROWS [PROBE_COUNT] = '{
		'{REQ_DIRTY, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, STAT_UNMAPPED, 8'd0},
		'{REQ_MAP,   32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, STAT_OK,       8'd0},
		'{REQ_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, STAT_MAPPED,   8'd0},
		'{REQ_MAP,   32'h0000_1000, 32'hFFFF_FFFF, 1'b1, 1'b1, STAT_OK,       8'd0},
		'{REQ_DIRTY, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, STAT_OK,       8'd0},
		'{REQ_DIRTY, 32'h0000_1000, 32'h0000_0000, 1'b0, 1'b1, STAT_OK,       8'd0},
		'{REQ_MAP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, STAT_OK,       8'd1},
		'{REQ_DIRTY, 32'hFFFF_E000, 32'h0000_0000, 1'b1, 1'b1, STAT_UNMAPPED, 8'd0},
		'{REQ_MAP,   32'hFFFF_E000, 32'h0000_0000, 1'b0, 1'b1, STAT_OK,       8'd1},
		'{REQ_MAP,   32'hFFFF_EFFF, 32'h0000_1234, 1'b0, 1'b1, STAT_MAPPED,   8'd0},
		'{REQ_DIRTY, 32'h0000_2000, 32'hFFFF_FFFF, 1'b1, 1'b1, STAT_UNMAPPED, 8'd0},
		'{REQ_MAP,   32'h0000_2FFF, 32'hA5A5_A000, 1'b1, 1'b1, STAT_OK,       8'd2},
		'{REQ_MAP,   32'h5555_4000, 32'hAAAA_A000, 1'b0, 1'b0, STAT_OK,       8'd0},
		'{REQ_DIRTY, 32'h5555_5000, 32'h0000_0000, 1'b1, 1'b0, STAT_OK,       8'd0},
		'{REQ_MAP,   32'hAAAA_B000, 32'h5555_5FFF, 1'b1, 1'b0, STAT_OK,       8'd0},
		'{REQ_DIRTY, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, STAT_OK,       8'd0},
		'{REQ_MAP,   32'h0000_0FFF, 32'h1234_5678, 1'b1, 1'b0, STAT_OK,       8'd0}
	};

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               start        = 1'b0;
	logic               req_type     = 1'b0;
	logic [31:0]        virt_addr    = '0;
	logic [31:0]        phys_addr    = '0;
	logic               write_enable = 1'b0;
	logic               cfg_valid    = 1'b0;
	logic [SPACE_W-1:0] cfg_data     = '0;
	logic               busy;
	logic               done;
	logic [1:0]         status;
	logic [SLOT_W-1:0]  slot;
	logic               cfg_ready;

	// Expected result attached to the request currently offered.
	logic               row_typed = 1'b0;
	status_t            row_st    = STAT_OK;
	logic [SLOT_W-1:0]  row_slot  = '0;

	// Model of the page table.
	logic [ENTRY_W-1:0] tag_tab  [TABLE_DEPTH];
	logic [HALF_W-1:0]  even_tab [TABLE_DEPTH];
	logic [HALF_W-1:0]  odd_tab  [TABLE_DEPTH];
	int                 fill_cnt  = 0;
	logic [SPACE_W-1:0] space_reg = '0;

	map_result_t        awaited_results [$];
	int                 errors        = 0;
	int                 quiet_cycles  = 0;
	int                 requests_sent = 0;
	int                 space_writes  = 0;
	int                 status_seen [4] = '{0, 0, 0, 0};

	paired_page_table_mapper u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.virt_addr    (virt_addr),
		.phys_addr    (phys_addr),
		.write_enable (write_enable),
		.done         (done),
		.status       (status),
		.slot         (slot),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #10 clk = ~clk;

	// Applies one request to the table model and returns the result it must produce.
	function automatic map_result_t apply_request(input logic rq, input logic [31:0] va,
		input logic [31:0] pa, input logic we);
		logic [TAG_W-1:0]  tag;
		logic [HALF_W-1:0] fresh;
		logic [HALF_W-1:0] cur;
		int                hit;
		map_result_t       r;
		tag   = va[31:TAG_LSB];
		fresh = {pa[31:FRAME_LSB], we, 1'b1};
		cur   = '0;
		hit   = -1;
		for (int i = 0; i < fill_cnt; i++)
			if (hit < 0 && tag_tab[i][ENTRY_W-1:SPACE_W] == tag)
				hit = i;
		r.st   = STAT_OK;
		r.slot = '0;
		if (hit >= 0)
			cur = va[ODD_BIT] ? odd_tab[hit] : even_tab[hit];
		if (rq == REQ_MAP) begin
			if (hit >= 0) begin
				if (cur[0]) begin
					r.st = STAT_MAPPED;
				end else begin
					if (va[ODD_BIT])
						odd_tab[hit] = fresh;
					else
						even_tab[hit] = fresh;
					r.slot = hit[SLOT_W-1:0];
				end
			end else if (fill_cnt >= TABLE_DEPTH) begin
				r.st = STAT_FULL;
			end else begin
				tag_tab[fill_cnt]  = {tag, space_reg};
				odd_tab[fill_cnt]  = va[ODD_BIT] ? fresh : '0;
				even_tab[fill_cnt] = va[ODD_BIT] ? '0 : fresh;
				r.slot = fill_cnt[SLOT_W-1:0];
				fill_cnt++;
			end
		end else if (hit < 0 || !cur[0]) begin
			r.st = STAT_UNMAPPED;
		end else begin
			cur[1] = we;
			if (va[ODD_BIT])
				odd_tab[hit] = cur;
			else
				even_tab[hit] = cur;
			r.slot = hit[SLOT_W-1:0];
		end
		return r;
	endfunction

	// Offers one request, idling first at the given rate, and returns after its beat.
	task automatic send_request(input logic rq, input logic [31:0] va, input logic [31:0] pa,
		input logic we, input logic typed, input status_t st, input logic [SLOT_W-1:0] sl,
		input int idle_pct);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			gap = $urandom_range(1, MAX_GAP);
			repeat (gap) begin
				req_type     = 1'($urandom);
				virt_addr    = $urandom;
				phys_addr    = $urandom;
				write_enable = 1'($urandom);
				@(negedge clk);
			end
		end
		req_type     = rq;
		virt_addr    = va;
		phys_addr    = pa;
		write_enable = we;
		row_typed    = typed;
		row_st       = st;
		row_slot     = sl;
		start        = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		@(negedge clk);
	endtask

	task automatic write_space_id(input logic [SPACE_W-1:0] value);
		cfg_data  = value;
		cfg_valid = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained;
		while (awaited_results.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		map_result_t want;
		logic        moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_valid && cfg_ready === 1'b1) begin
				space_reg = cfg_data;
				space_writes++;
				moved = 1'b1;
			end
			if (start && busy === 1'b0) begin
				want = apply_request(req_type, virt_addr, phys_addr, write_enable);
				if (row_typed)
					want = '{row_st, row_slot};
				awaited_results.push_back(want);
				requests_sent++;
				moved = 1'b1;
			end
			if (done === 1'b1) begin
				moved = 1'b1;
				if (awaited_results.size() == 0) begin
					$display("%0t: result with none expected: status %0d slot %0d",
						$time, status, slot);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					status_seen[int'(want.st)]++;
					if (status !== want.st) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.st, status);
						errors++;
					end
					if (slot !== want.slot) begin
						$display("%0t: slot mismatch: expected %0d, actual %0d",
							$time, want.slot, slot);
						errors++;
					end
				end
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("paired_page_table_mapper test failed");
			$finish;
		end
	end

	initial begin
		int                 idle_pct [3];
		logic [SPACE_W-1:0] phase_space [3];
		logic               rq;
		logic [TAG_W-1:0]   tag;
		int                 pick;
		idle_pct    = '{36, 57, 0};
		phase_space = '{8'h00, 8'($urandom), 8'hFF};
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_space_id(8'hFF);

		for (int r = 0; r < PROBE_COUNT; r++)
			send_request(PROBE_ROWS[r].rq, PROBE_ROWS[r].va, PROBE_ROWS[r].pa,
				PROBE_ROWS[r].we, PROBE_ROWS[r].typed, PROBE_ROWS[r].st,
				PROBE_ROWS[r].slot, 0);

		for (int ph = 0; ph < 3; ph++) begin
			start = 1'b0;
			wait_drained();
			write_space_id(phase_space[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				rq = ($urandom_range(99) < 60) ? REQ_MAP : REQ_DIRTY;
				if (fill_cnt > 0 && $urandom_range(99) < ((rq == REQ_MAP) ? 40 : 75)) begin
					pick = $urandom_range(fill_cnt - 1);
					tag  = tag_tab[pick][ENTRY_W-1:SPACE_W];
				end else begin
					tag = TAG_W'($urandom);
				end
				send_request(rq, {tag, 13'($urandom)}, $urandom, 1'($urandom), 1'b0,
					STAT_OK, '0, idle_pct[ph]);
			end
		end

		start = 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Ran %0d requests (%0d directed) under three idle rates, %0d space id writes, %0d of %0d entries filled.",
			requests_sent, PROBE_COUNT, space_writes, fill_cnt, TABLE_DEPTH);
		$display("Outcomes: %0d ok, %0d remaps refused, %0d table full, %0d not mapped.",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (errors == 0)
			$display("paired_page_table_mapper test passed");
		else
			$display("paired_page_table_mapper test failed");
		$finish;
	end

endmodule
